>>> hw/rtl/scal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scal_pkg
// Shared constants, record types, status codes and size-class arithmetic
// for the slab size-class allocator.
// ----------------------------------------------------------------------------
package scal_pkg;

  // Pool geometry.
  localparam int NUM_BLOCKS   = 128;
  localparam int HEADER_BYTES = 32;
  localparam int MAX_UNITS    = 1024;

  // Size-class layout: fine steps first, then coarse steps.
  localparam int STEP1_SH    = 4;
  localparam int STEP2_SH    = 6;
  localparam int COUNT1      = 128;
  localparam int COUNT2      = 608;
  localparam int SPAN1       = COUNT1 << STEP1_SH;
  localparam int SPAN        = SPAN1 + (COUNT2 << STEP2_SH);
  localparam int NUM_CLASSES = COUNT1 + COUNT2 + 1;

  // Widths.
  localparam int BLK_W   = $clog2(NUM_BLOCKS);
  localparam int LNK_W   = $clog2(NUM_BLOCKS + 1);
  localparam int UNIT_W  = $clog2(MAX_UNITS);
  localparam int UCNT_W  = $clog2(MAX_UNITS + 1);
  localparam int CLS_W   = $clog2(NUM_CLASSES);
  localparam int BYTES_W = 16;
  localparam int CB_W    = 17;
  localparam int PROD_W  = UCNT_W + 1 + CB_W;
  localparam int UADDR_W = BLK_W + UNIT_W;
  localparam int USE_W   = 32;

  // Empty-link markers, one past the last valid index.
  localparam logic [LNK_W-1:0]  BNIL = LNK_W'(NUM_BLOCKS);
  localparam logic [UCNT_W-1:0] UNIL = UCNT_W'(MAX_UNITS);

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO       = 3'd1,
    ST_TOO_LARGE  = 3'd2,
    ST_NO_BLOCK   = 3'd3,
    ST_NOT_ALLOC  = 3'd4,
    ST_BAD_HANDLE = 3'd5
  } status_t;

  // Per-block record held in the block memory.
  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [UCNT_W-1:0] used;
    logic [UCNT_W-1:0] hw;
    logic [UCNT_W-1:0] fhead;
    logic              onp;
  } blk_rec_t;

  // Per-unit record held in the unit memory.
  typedef struct packed {
    logic               alloc;
    logic [BYTES_W-1:0] bytes;
    logic [UCNT_W-1:0]  next;
  } unit_rec_t;

  // Decoded request size.
  typedef struct packed {
    status_t          st;
    logic [CLS_W-1:0] cls;
  } cls_info_t;

  // Payload bytes of one unit of class c.
  function automatic logic [CB_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
    logic [CB_W-1:0] cx;
    cx = CB_W'(c);
    if (cx <= CB_W'(COUNT1)) begin
      class_bytes = cx << STEP1_SH;
    end else begin
      class_bytes = ((cx - CB_W'(COUNT1)) << STEP2_SH) + CB_W'(SPAN1);
    end
  endfunction

endpackage

>>> hw/rtl/scal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scal_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module scal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/scal_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scal_class
// Maps a request size to its size class and flags zero and oversize requests.
// ----------------------------------------------------------------------------
module scal_class import scal_pkg::*; (
  input  logic [BYTES_W-1:0] request_bytes,
  output cls_info_t          info
);

  logic [CB_W-1:0]  sz;
  logic [CB_W-1:0]  c_fine;
  logic [CB_W-1:0]  c_coarse;
  logic [CLS_W-1:0] cls_c;
  logic [CB_W-1:0]  cb;

  // Round up to the class step of the matching range.
  always_comb begin
    sz       = CB_W'(request_bytes);
    c_fine   = (sz + CB_W'((1 << STEP1_SH) - 1)) >> STEP1_SH;
    c_coarse = ((sz - CB_W'(SPAN1) + CB_W'((1 << STEP2_SH) - 1)) >> STEP2_SH)
               + CB_W'(COUNT1);
    cls_c    = (sz <= CB_W'(SPAN1)) ? CLS_W'(c_fine) : CLS_W'(c_coarse);
    cb       = class_bytes(cls_c);
  end

  // A unit must fit in the block span together with its header.
  always_comb begin
    if (request_bytes == '0) begin
      info.st  = ST_ZERO;
      info.cls = '0;
    end else if (sz > CB_W'(SPAN)) begin
      info.st  = ST_TOO_LARGE;
      info.cls = '0;
    end else if (cb > CB_W'(SPAN - HEADER_BYTES)) begin
      info.st  = ST_TOO_LARGE;
      info.cls = cls_c;
    end else begin
      info.st  = ST_OK;
      info.cls = cls_c;
    end
  end

endmodule

>>> hw/rtl/slab_size_class_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_size_class_allocator_unit
// Segregated-fit slab allocator: allocates and frees units from size-class
// lists of partly filled blocks kept in on-chip memories.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   in      | in_valid/in_stall  | mode, request_bytes, handle_block, handle_unit
//   out     | out_valid/out_stall| status, granted_block, granted_unit,
//           |                    | size_class, bytes_in_use
//
// After a word is accepted, out_valid rises once the steps of its allocate or
// free are done and the output register is free, one word at a time; each step
// waits on a dependent read of the class-head, link, block or unit memory, all
// with registered read ports. in_stall drops with the result, so the next word
// is taken at the following edge at the earliest.
// After reset a clearing pass empties every class list with in_stall high.
// A finished word waits in the output register; the next word is taken
// while it is stalled, and only the hand-over of a later result waits.
// ----------------------------------------------------------------------------
module slab_size_class_allocator_unit import scal_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [BYTES_W-1:0] request_bytes,
  input  logic [BLK_W-1:0]   handle_block,
  input  logic [UNIT_W-1:0]  handle_unit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [BLK_W-1:0]   granted_block,
  output logic [UNIT_W-1:0]  granted_unit,
  output logic [CLS_W-1:0]   size_class,
  output logic [USE_W-1:0]   bytes_in_use
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_A_DEC, S_A_HEAD, S_A_POOL, S_A_NEW, S_A_BLK, S_A_SEL, S_A_UNIT,
    S_A_MUL, S_A_UPD, S_UNLINK,
    S_F_RD, S_F_CHK, S_F_PUSH, S_F_PREV, S_F_POOL,
    S_DONE
  } state_t;

  state_t state;

  // Request and working registers.
  logic               req_mode;
  logic [BYTES_W-1:0] req_bytes;
  logic [BLK_W-1:0]   req_blk;
  logic [UNIT_W-1:0]  req_unit;
  logic [CLS_W-1:0]   cls;
  logic [BLK_W-1:0]   blk;
  logic [UNIT_W-1:0]  unit;
  blk_rec_t           rec;
  logic [PROD_W-1:0]  prod;
  logic [LNK_W-1:0]   pool_head;
  logic [LNK_W-1:0]   fresh;
  logic [USE_W-1:0]   usage;
  logic [CLS_W-1:0]   clr_cnt;
  status_t            res_st;
  logic [BLK_W-1:0]   res_gb;
  logic [UNIT_W-1:0]  res_gu;
  logic [CLS_W-1:0]   res_cls;

  // Memory ports.
  logic                    head_we;
  logic [CLS_W-1:0]        head_waddr, head_raddr;
  logic [LNK_W-1:0]        head_wdata, head_rd;
  logic                    prev_we;
  logic [BLK_W-1:0]        prev_waddr, prev_raddr;
  logic [LNK_W-1:0]        prev_wdata, prev_rd;
  logic                    next_we;
  logic [BLK_W-1:0]        next_waddr, next_raddr;
  logic [LNK_W-1:0]        next_wdata, next_rd;
  logic                    blk_we;
  logic [BLK_W-1:0]        blk_waddr, blk_raddr;
  blk_rec_t                blk_wdata, blk_rd;
  logic                    unit_we;
  logic [UADDR_W-1:0]      unit_waddr, unit_raddr;
  unit_rec_t               unit_wdata, unit_rd;

  // Derived values.
  cls_info_t          dec;
  logic [CB_W-1:0]    slot_bytes;
  logic               unl;
  logic [USE_W:0]     usage_sum;
  logic [USE_W-1:0]   usage_add;
  logic [USE_W-1:0]   usage_sub;
  logic [UCNT_W-1:0]  used_dec;
  logic               unit_ok;
  logic [LNK_W-1:0]   p_lnk, n_lnk;

  scal_class u_class (
    .request_bytes (req_bytes),
    .info          (dec)
  );

  scal_ram #(.WIDTH(LNK_W), .DEPTH(NUM_CLASSES)) u_head_mem (
    .clk (clk), .we (head_we), .waddr (head_waddr), .wdata (head_wdata),
    .raddr (head_raddr), .rdata (head_rd)
  );

  scal_ram #(.WIDTH(LNK_W), .DEPTH(NUM_BLOCKS)) u_prev_mem (
    .clk (clk), .we (prev_we), .waddr (prev_waddr), .wdata (prev_wdata),
    .raddr (prev_raddr), .rdata (prev_rd)
  );

  scal_ram #(.WIDTH(LNK_W), .DEPTH(NUM_BLOCKS)) u_next_mem (
    .clk (clk), .we (next_we), .waddr (next_waddr), .wdata (next_wdata),
    .raddr (next_raddr), .rdata (next_rd)
  );

  scal_ram #(.WIDTH($bits(blk_rec_t)), .DEPTH(NUM_BLOCKS)) u_blk_mem (
    .clk (clk), .we (blk_we), .waddr (blk_waddr), .wdata (blk_wdata),
    .raddr (blk_raddr), .rdata (blk_rd)
  );

  scal_ram #(.WIDTH($bits(unit_rec_t)), .DEPTH(NUM_BLOCKS * MAX_UNITS)) u_unit_mem (
    .clk (clk), .we (unit_we), .waddr (unit_waddr), .wdata (unit_wdata),
    .raddr (unit_raddr), .rdata (unit_rd)
  );

  assign in_stall = (state != S_IDLE);

  // Arithmetic shared by the sequencer and the memory ports.
  always_comb begin
    slot_bytes = class_bytes(cls) + CB_W'(HEADER_BYTES);
    // The block is full once no freed unit is left and the high-water mark
    // has reached the unit count of its class.
    unl       = (rec.fhead >= UNIL) &&
                ((prod > PROD_W'(SPAN)) || (rec.hw >= UNIL));
    usage_sum = {1'b0, usage} + (USE_W + 1)'(req_bytes);
    usage_add = usage_sum[USE_W] ? '1 : usage_sum[USE_W-1:0];
    usage_sub = (usage < USE_W'(unit_rd.bytes)) ? '0 : usage - USE_W'(unit_rd.bytes);
    used_dec  = (blk_rd.used == '0) ? '0 : blk_rd.used - UCNT_W'(1);
    // A unit beyond the high-water mark was never handed out since issue.
    unit_ok   = unit_rd.alloc && (UCNT_W'(req_unit) < blk_rd.hw);
    p_lnk     = prev_rd;
    n_lnk     = next_rd;
  end

  // Memory addresses and writes per step.
  always_comb begin
    head_we    = 1'b0;
    head_waddr = cls;
    head_wdata = LNK_W'(blk);
    head_raddr = cls;
    prev_we    = 1'b0;
    prev_waddr = blk;
    prev_wdata = BNIL;
    prev_raddr = blk;
    next_we    = 1'b0;
    next_waddr = blk;
    next_wdata = BNIL;
    next_raddr = blk;
    blk_we     = 1'b0;
    blk_waddr  = blk;
    blk_wdata  = rec;
    blk_raddr  = blk;
    unit_we    = 1'b0;
    unit_waddr = {blk, unit};
    unit_wdata = '{alloc: 1'b1, bytes: req_bytes, next: rec.fhead};
    unit_raddr = {blk, unit};

    unique case (state)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_cnt;
        head_wdata = BNIL;
      end
      S_A_DEC: begin
        head_raddr = dec.cls;
      end
      S_A_HEAD: begin
        blk_raddr  = head_rd[BLK_W-1:0];
        next_raddr = pool_head[BLK_W-1:0];
      end
      S_A_NEW: begin
        // New block becomes the only member of its class list.
        prev_we = 1'b1;
        next_we = 1'b1;
        head_we = 1'b1;
      end
      S_A_SEL: begin
        unit_raddr = {blk, rec.fhead[UNIT_W-1:0]};
      end
      S_A_UPD: begin
        blk_we        = 1'b1;
        blk_wdata.onp = rec.onp & ~unl;
        unit_we       = 1'b1;
      end
      S_UNLINK: begin
        if (p_lnk == BNIL) begin
          head_we    = 1'b1;
          head_wdata = n_lnk;
        end else if (p_lnk < BNIL) begin
          next_we    = 1'b1;
          next_waddr = p_lnk[BLK_W-1:0];
          next_wdata = n_lnk;
        end
        if (n_lnk < BNIL) begin
          prev_we    = 1'b1;
          prev_waddr = n_lnk[BLK_W-1:0];
          prev_wdata = p_lnk;
        end
      end
      S_F_RD: begin
        blk_raddr  = req_blk;
        unit_raddr = {req_blk, req_unit};
      end
      S_F_CHK: begin
        head_raddr = blk_rd.cls;
        if (unit_ok) begin
          unit_we          = 1'b1;
          unit_wdata.alloc = 1'b0;
          unit_wdata.bytes = unit_rd.bytes;
          unit_wdata.next  = (used_dec == '0) ? unit_rd.next : blk_rd.fhead;
          if (used_dec == '0) begin
            blk_we         = 1'b1;
            blk_wdata      = blk_rd;
            blk_wdata.used = '0;
            blk_wdata.onp  = 1'b0;
          end else if (blk_rd.onp) begin
            blk_we          = 1'b1;
            blk_wdata       = blk_rd;
            blk_wdata.used  = used_dec;
            blk_wdata.fhead = UCNT_W'(unit);
          end
        end
      end
      S_F_PUSH: begin
        // Block goes to the head of its class list.
        if (head_rd < BNIL) begin
          prev_we    = 1'b1;
          prev_waddr = head_rd[BLK_W-1:0];
          prev_wdata = LNK_W'(blk);
        end
        next_we    = 1'b1;
        next_wdata = head_rd;
        head_we    = 1'b1;
        blk_we     = 1'b1;
      end
      S_F_PREV: begin
        prev_we = 1'b1;
      end
      S_F_POOL: begin
        next_we    = 1'b1;
        next_wdata = pool_head;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, working registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      pool_head <= BNIL;
      fresh     <= '0;
      usage     <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken word leaves the output register unless a new one replaces it.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CLS_W'(1);
          if (clr_cnt == CLS_W'(NUM_CLASSES - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            req_mode  <= mode;
            req_bytes <= request_bytes;
            req_blk   <= handle_block;
            req_unit  <= handle_unit;
            res_st    <= ST_OK;
            res_gb    <= '0;
            res_gu    <= '0;
            res_cls   <= '0;
            state     <= mode ? S_F_RD : S_A_DEC;
          end
        end

        // Allocation path.
        S_A_DEC: begin
          cls     <= dec.cls;
          res_cls <= dec.cls;
          res_st  <= dec.st;
          state   <= (dec.st == ST_OK) ? S_A_HEAD : S_DONE;
        end

        S_A_HEAD: begin
          if (head_rd < BNIL) begin
            blk   <= head_rd[BLK_W-1:0];
            state <= S_A_BLK;
          end else if (pool_head < BNIL) begin
            blk   <= pool_head[BLK_W-1:0];
            state <= S_A_POOL;
          end else if (fresh < BNIL) begin
            blk   <= fresh[BLK_W-1:0];
            fresh <= fresh + LNK_W'(1);
            state <= S_A_NEW;
          end else begin
            res_st  <= ST_NO_BLOCK;
            state   <= S_DONE;
          end
        end

        S_A_POOL: begin
          pool_head <= next_rd;
          state     <= S_A_NEW;
        end

        S_A_NEW: begin
          rec   <= '{cls: cls, used: '0, hw: '0, fhead: UNIL, onp: 1'b1};
          state <= S_A_SEL;
        end

        S_A_BLK: begin
          rec   <= blk_rd;
          state <= S_A_SEL;
        end

        S_A_SEL: begin
          if (rec.fhead < UNIL) begin
            unit  <= rec.fhead[UNIT_W-1:0];
            state <= S_A_UNIT;
          end else begin
            unit   <= (rec.hw >= UNIL) ? UNIT_W'(MAX_UNITS - 1) : rec.hw[UNIT_W-1:0];
            rec.hw <= rec.hw + UCNT_W'(1);
            state  <= S_A_MUL;
          end
        end

        S_A_UNIT: begin
          rec.fhead <= unit_rd.next;
          state     <= S_A_MUL;
        end

        S_A_MUL: begin
          prod     <= PROD_W'((UCNT_W + 1)'(rec.hw) + (UCNT_W + 1)'(1)) *
                      PROD_W'(slot_bytes);
          rec.used <= rec.used + UCNT_W'(1);
          state    <= S_A_UPD;
        end

        S_A_UPD: begin
          usage  <= usage_add;
          res_gb <= blk;
          res_gu <= unit;
          state  <= unl ? S_UNLINK : S_DONE;
        end

        S_UNLINK: begin
          state <= req_mode ? S_F_POOL : S_DONE;
        end

        // Free path.
        S_F_RD: begin
          blk  <= req_blk;
          unit <= req_unit;
          if ((LNK_W'(req_blk) >= BNIL) || (UCNT_W'(req_unit) >= UNIL)) begin
            res_st <= ST_BAD_HANDLE;
            state  <= S_DONE;
          end else if (LNK_W'(req_blk) >= fresh) begin
            res_st <= ST_NOT_ALLOC;
            state  <= S_DONE;
          end else begin
            state <= S_F_CHK;
          end
        end

        S_F_CHK: begin
          if (!unit_ok) begin
            res_st <= ST_NOT_ALLOC;
            state  <= S_DONE;
          end else begin
            cls     <= blk_rd.cls;
            res_cls <= blk_rd.cls;
            usage   <= usage_sub;
            rec     <= '{cls: blk_rd.cls, used: used_dec, hw: blk_rd.hw,
                         fhead: UCNT_W'(unit), onp: 1'b1};
            if (used_dec == '0) begin
              state <= blk_rd.onp ? S_UNLINK : S_F_POOL;
            end else begin
              state <= blk_rd.onp ? S_DONE : S_F_PUSH;
            end
          end
        end

        S_F_PUSH: begin
          state <= S_F_PREV;
        end

        S_F_PREV: begin
          state <= S_DONE;
        end

        S_F_POOL: begin
          pool_head <= LNK_W'(blk);
          state     <= S_DONE;
        end

        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (!(out_valid && out_stall)) begin
            out_valid     <= 1'b1;
            status        <= res_st;
            granted_block <= res_gb;
            granted_unit  <= res_gu;
            size_class    <= res_cls;
            bytes_in_use  <= usage;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/scal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scal_checker
// Port-level checks of the slab allocator's result words.
// ----------------------------------------------------------------------------
module scal_checker import scal_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         status,
  input logic [BLK_W-1:0]   granted_block,
  input logic [UNIT_W-1:0]  granted_unit,
  input logic [CLS_W-1:0]   size_class,
  input logic [USE_W-1:0]   bytes_in_use
);

  // A stalled result word stays valid and holds its status, unit and byte count.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(granted_unit) && $stable(bytes_in_use))
    else $error("stalled result word changed");

  // Only a granted allocation carries a unit.
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (granted_block == '0) && (granted_unit == '0))
    else $error("unit reported on a failed request");

  // Zero-size and bad frees carry no class.
  a_cls_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == ST_ZERO) || (status == ST_NOT_ALLOC) ||
      (status == ST_BAD_HANDLE)) |-> (size_class == '0))
    else $error("class reported on a request without one");

  // A successful word always names a real class.
  a_cls_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |-> (size_class != '0) &&
      (size_class < CLS_W'(NUM_CLASSES)))
    else $error("successful word with an empty class");

  // Status stays within the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_BAD_HANDLE))
    else $error("undefined status code");

endmodule

bind slab_size_class_allocator_unit scal_checker u_scal_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the slab size-class allocator. Directed tests cover the size
// extremes, class boundaries, bad frees, pool exhaustion and block recycling;
// a random phase then mixes allocations and frees of live units. A predictor
// tracks the class lists, blocks and units and checks every result word in
// order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import scal_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NCLS = COUNT1 + COUNT2 + 1;

  typedef struct {
    logic [2:0]  st;
    logic [6:0]  blk;
    logic [9:0]  unit;
    logic [9:0]  cls;
    logic [31:0] usage;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic [15:0] request_bytes = '0;
  logic [6:0] handle_block = '0;
  logic [9:0] handle_unit = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [6:0] granted_block;
  logic [9:0] granted_unit;
  logic [9:0] size_class;
  logic [31:0] bytes_in_use;

  // Allocator state as the predictor sees it.
  int cls_head [NCLS];
  int blk_prev [NUM_BLOCKS];
  int blk_next [NUM_BLOCKS];
  bit blk_onp [NUM_BLOCKS];
  int blk_cls [NUM_BLOCKS];
  int blk_used [NUM_BLOCKS];
  int blk_hw [NUM_BLOCKS];
  int blk_fhead [NUM_BLOCKS];
  int pool_top;
  int fresh_cnt;
  int unit_link [NUM_BLOCKS*MAX_UNITS];
  bit unit_live [NUM_BLOCKS*MAX_UNITS];
  int unit_len [NUM_BLOCKS*MAX_UNITS];
  longint usage_sum;

  grant_t pending_grants[$];
  int live_units[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  slab_size_class_allocator_unit dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver stall: the pattern steps through no stall, random, periodic and mostly-stalled phases.
  always @(negedge clk) begin
    case ((cycles / 300) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ((cycles % 7) < 3);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Check each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    grant_t g;
    if (!rst && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected word st=%0d blk=%0d unit=%0d cls=%0d use=%0d",
                 $time, status, granted_block, granted_unit, size_class, bytes_in_use);
        errors++;
      end else begin
        g = pending_grants.pop_front();
        if (status !== g.st) begin
          $display("%0t: status exp %0d got %0d", $time, g.st, status);
          errors++;
        end
        if (granted_block !== g.blk) begin
          $display("%0t: granted_block exp %0d got %0d", $time, g.blk, granted_block);
          errors++;
        end
        if (granted_unit !== g.unit) begin
          $display("%0t: granted_unit exp %0d got %0d", $time, g.unit, granted_unit);
          errors++;
        end
        if (size_class !== g.cls) begin
          $display("%0t: size_class exp %0d got %0d", $time, g.cls, size_class);
          errors++;
        end
        if (bytes_in_use !== g.usage) begin
          $display("%0t: bytes_in_use exp %0d got %0d", $time, g.usage, bytes_in_use);
          errors++;
        end
      end
    end
  end

  function automatic int payload_of(int c);
    if (c <= COUNT1) return c * 16;
    return (c - COUNT1) * 64 + SPAN1;
  endfunction

  function automatic int units_per_block(int c);
    int n;
    n = SPAN / (payload_of(c) + HEADER_BYTES);
    return (n > MAX_UNITS) ? MAX_UNITS : n;
  endfunction

  function automatic void list_remove(int b);
    int p, n;
    p = blk_prev[b];
    n = blk_next[b];
    if (p == NUM_BLOCKS) cls_head[blk_cls[b]] = n;
    else blk_next[p] = n;
    if (n < NUM_BLOCKS) blk_prev[n] = p;
    blk_onp[b] = 0;
  endfunction

  function automatic void list_push(int b);
    int h;
    h = cls_head[blk_cls[b]];
    if (h < NUM_BLOCKS) blk_prev[h] = b;
    blk_prev[b] = NUM_BLOCKS;
    blk_next[b] = h;
    cls_head[blk_cls[b]] = b;
    blk_onp[b] = 1;
  endfunction

  function automatic void clear_allocator();
    foreach (cls_head[i]) cls_head[i] = NUM_BLOCKS;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      blk_onp[i] = 0;
      blk_used[i] = 0;
    end
    foreach (unit_live[i]) unit_live[i] = 0;
    pool_top = NUM_BLOCKS;
    fresh_cnt = 0;
    usage_sum = 0;
  endfunction

  // Work out the result word of one request and update the allocator state.
  function automatic grant_t allocate_or_free(bit m, int sz, int hb, int hu);
    grant_t g;
    int b, u, idx, c;
    g = '{st: ST_OK, blk: 0, unit: 0, cls: 0, usage: 0};
    if (!m) begin
      if (sz == 0) g.st = ST_ZERO;
      else if (sz > SPAN) g.st = ST_TOO_LARGE;
      else begin
        c = (sz <= SPAN1) ? (sz + 15) / 16 : (sz - SPAN1 + 63) / 64 + COUNT1;
        g.cls = 10'(c);
        if (payload_of(c) > SPAN - HEADER_BYTES) g.st = ST_TOO_LARGE;
        else begin
          b = cls_head[c];
          if (b >= NUM_BLOCKS) begin
            if (pool_top < NUM_BLOCKS) begin
              b = pool_top;
              pool_top = blk_next[b];
            end else if (fresh_cnt < NUM_BLOCKS) begin
              b = fresh_cnt;
              fresh_cnt++;
            end else b = -1;
            if (b >= 0) begin
              blk_cls[b] = c;
              blk_used[b] = 0;
              blk_hw[b] = 0;
              blk_fhead[b] = MAX_UNITS;
              list_push(b);
            end
          end
          if (b < 0) g.st = ST_NO_BLOCK;
          else begin
            if (blk_fhead[b] < MAX_UNITS) begin
              u = blk_fhead[b];
              blk_fhead[b] = unit_link[b*MAX_UNITS + u];
            end else begin
              u = (blk_hw[b] >= MAX_UNITS) ? MAX_UNITS - 1 : blk_hw[b];
              blk_hw[b]++;
            end
            blk_used[b]++;
            if (blk_fhead[b] >= MAX_UNITS && blk_hw[b] >= units_per_block(c))
              list_remove(b);
            idx = b*MAX_UNITS + u;
            unit_live[idx] = 1;
            unit_len[idx] = sz;
            usage_sum = usage_sum + sz;
            if (usage_sum > 64'hFFFF_FFFF) usage_sum = 64'hFFFF_FFFF;
            g.blk = 7'(b);
            g.unit = 10'(u);
          end
        end
      end
    end else if (hb >= NUM_BLOCKS || hu >= MAX_UNITS) g.st = ST_BAD_HANDLE;
    else begin
      idx = hb*MAX_UNITS + hu;
      if (!unit_live[idx]) g.st = ST_NOT_ALLOC;
      else begin
        g.cls = 10'(blk_cls[hb]);
        usage_sum = (usage_sum < unit_len[idx]) ? 0 : usage_sum - unit_len[idx];
        unit_live[idx] = 0;
        if (blk_used[hb] > 0) blk_used[hb]--;
        if (blk_used[hb] == 0) begin
          if (blk_onp[hb]) list_remove(hb);
          blk_next[hb] = pool_top;
          pool_top = hb;
        end else begin
          if (!blk_onp[hb]) list_push(hb);
          unit_link[idx] = blk_fhead[hb];
          blk_fhead[hb] = hu;
        end
      end
    end
    g.usage = usage_sum[31:0];
    return g;
  endfunction

  // Send one word in bursts with random gaps, then record its prediction.
  task automatic send_word(bit m, int sz, int hb, int hu);
    grant_t g;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    request_bytes <= sz[15:0];
    handle_block <= hb[6:0];
    handle_unit <= hu[9:0];
    do @(posedge clk); while (in_stall);
    // The block sees only the port bits of each field.
    g = allocate_or_free(m, int'(sz[15:0]), int'(hb[6:0]), int'(hu[9:0]));
    pending_grants.push_back(g);
    if (!m && g.st == ST_OK) live_units.push_back(g.blk*MAX_UNITS + g.unit);
    if (m && g.st == ST_OK)
      foreach (live_units[i])
        if (live_units[i] == int'(hb[6:0]) * MAX_UNITS + int'(hu[9:0])) begin
          live_units.delete(i);
          break;
        end
  endtask

  task automatic free_live(int k);
    int h;
    h = live_units[k];
    send_word(1'b1, $urandom, h / MAX_UNITS, h % MAX_UNITS);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // Size extremes, class boundaries and bad frees.
  task automatic test_edges();
    send_word(1'b0, 0, 0, 0);
    send_word(1'b0, 65535, 127, 1023);
    send_word(1'b0, SPAN + 1, 0, 0);
    send_word(1'b0, SPAN, 0, 0);
    send_word(1'b0, SPAN - HEADER_BYTES, 0, 0);
    send_word(1'b0, SPAN - 64, 0, 0);
    send_word(1'b0, 1, 0, 0);
    send_word(1'b0, 16, 0, 0);
    send_word(1'b0, 17, 0, 0);
    send_word(1'b0, SPAN1, 0, 0);
    send_word(1'b0, SPAN1 + 1, 0, 0);
    send_word(1'b1, 0, 0, 1);
    send_word(1'b1, 0, 127, 1023);
    send_word(1'b1, 0, 0, 0);
    send_word(1'b1, 0, 0, 0);
    send_word(1'b1, 0, 0, 1);
    send_word(1'b0, 8, 0, 0);
  endtask

  // Take every block in distinct classes, hit the empty pool, then free all.
  task automatic test_exhaust();
    for (int i = 0; i < NUM_BLOCKS + 2; i++)
      send_word(1'b0, SPAN1 + 64 * (i + 1), 0, 0);
    send_word(1'b0, 33, 0, 0);
    while (live_units.size() > 0) free_live($urandom_range(0, live_units.size() - 1));
  endtask

  // Random mix of allocations and frees, mostly on live units.
  task automatic test_random(int count);
    int r, sz;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (live_units.size() > 0 && (r < 40 || (live_units.size() > 400 && r < 70)))
        free_live($urandom_range(0, live_units.size() - 1));
      else if (r < 47) send_word(1'b1, $urandom, $urandom, $urandom);
      else begin
        r = $urandom_range(0, 99);
        if (r < 60) sz = $urandom_range(1, 4) * 16 - $urandom_range(0, 15);
        else if (r < 85) sz = $urandom_range(1, SPAN);
        else if (r < 97) sz = $urandom_range(0, 65535);
        else sz = 0;
        send_word(1'b0, sz, $urandom, $urandom);
      end
      if (n == count / 2) drain();
    end
  endtask

  initial begin
    clear_allocator();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_edges();
    drain();
    test_exhaust();
    test_random(1200);
    drain();
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/scal_pkg.sv
hw/rtl/scal_ram.sv
hw/rtl/scal_class.sv
hw/rtl/slab_size_class_allocator_unit.sv
hw/rtl/scal_checker.sv
sim/tb.sv
